// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros for the RTL: an overlapping and a
// next-cycle implication, both sampled on the rising clock edge and
// switched off while the active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== hw/rtl/pur_pkg.sv =====
// ----------------------------------------------------------------------------
// pur_pkg
// Types, constants and the factorial weight table of the permutation
// unranking unit.
// ----------------------------------------------------------------------------
package pur_pkg;

    localparam int unsigned NUM_ELEM = 10;
    localparam int unsigned ELEM_W   = 4;
    localparam int unsigned RANK_W   = 22;
    localparam int unsigned CNT_W    = 4;

    localparam logic [RANK_W-1:0] RANK_LIMIT = 22'd3628800;
    localparam logic [CNT_W-1:0]  LAST_IDX   = CNT_W'(NUM_ELEM - 1);

    typedef logic [ELEM_W-1:0] t_elem;

    typedef struct packed {
        logic  used;
        t_elem elem;
    } t_cell;

    // Weight of the digit picked in a given pass: (9 - pass)!.
    function automatic logic [RANK_W-1:0] fact_weight(input logic [CNT_W-1:0] pass);
        logic [RANK_W-1:0] w;
        case (pass)
            4'd0:    w = 22'd362880;
            4'd1:    w = 22'd40320;
            4'd2:    w = 22'd5040;
            4'd3:    w = 22'd720;
            4'd4:    w = 22'd120;
            4'd5:    w = 22'd24;
            4'd6:    w = 22'd6;
            4'd7:    w = 22'd2;
            4'd8:    w = 22'd1;
            4'd9:    w = 22'd1;
            default: w = 22'd1;
        endcase
        return w;
    endfunction

endpackage

// ===== hw/rtl/pur_cell.sv =====
// ----------------------------------------------------------------------------
// pur_cell
// One cell of the element ring: holds an element and its used flag, loads
// the identity entry on a new transfer and takes its neighbor's entry
// on every cycle of the scan.
// ----------------------------------------------------------------------------
module pur_cell (
    input  logic           i_clk,
    input  logic           i_load,
    input  pur_pkg::t_cell i_init,
    input  logic           i_shift,
    input  pur_pkg::t_cell i_next,
    output pur_pkg::t_cell o_cell
);
    import pur_pkg::*;

    t_cell r_cell;
    t_cell n_cell;

    always_comb begin
        n_cell = r_cell;
        if (i_load) begin
            n_cell = i_init;
        end else if (i_shift) begin
            n_cell = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cell <= n_cell;
    end

    assign o_cell = r_cell;

endmodule

// ===== hw/rtl/permutation_unrank_ten_unit.sv =====
// ----------------------------------------------------------------------------
// permutation_unrank_ten_unit
// Turns a rank 0..10!-1 into the permutation of 0..9 that the factorial
// number system gives; ranks of 10! or more give the identity, flagged.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive i_rank and raise start; the transfer happens at a
//   rising edge with start high and busy low. busy stays high while a rank
//   is being worked on.
//   Result channel: o_strobe is high for exactly one cycle with
//   o_perm_0..o_perm_9 and o_rank_ok; the receiver cannot stall, so take
//   the result in that cycle. The result registers hold afterwards.
//   A valid rank gives its strobe when the scan ends and the unit
//   returns to idle. An out-of-range rank gives its strobe in the
//   cycle right after the transfer. A new rank may be transferred in the
//   strobe cycle, but is not taken while a valid rank is in the scan.
//   The scan is set by the element ring: ten passes, each a full
//   revolution of the ten cells past the head, one cell per cycle.
//   Reset (synchronous, active low) drops any rank in flight, clears the
//   strobe and returns to idle; no result is given for a dropped rank.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module permutation_unrank_ten_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [pur_pkg::RANK_W-1:0] i_rank,
    output logic                      o_strobe,
    output logic [pur_pkg::ELEM_W-1:0] o_perm_0,
    output logic [pur_pkg::ELEM_W-1:0] o_perm_1,
    output logic [pur_pkg::ELEM_W-1:0] o_perm_2,
    output logic [pur_pkg::ELEM_W-1:0] o_perm_3,
    output logic [pur_pkg::ELEM_W-1:0] o_perm_4,
    output logic [pur_pkg::ELEM_W-1:0] o_perm_5,
    output logic [pur_pkg::ELEM_W-1:0] o_perm_6,
    output logic [pur_pkg::ELEM_W-1:0] o_perm_7,
    output logic [pur_pkg::ELEM_W-1:0] o_perm_8,
    output logic [pur_pkg::ELEM_W-1:0] o_perm_9,
    output logic                      o_rank_ok
);
    import pur_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    t_state            r_state;
    logic              r_strobe;
    logic              r_rank_ok;
    logic              r_picked;
    logic [CNT_W-1:0]  r_cyc;
    logic [CNT_W-1:0]  r_pass;
    logic [RANK_W-1:0] r_rank;
    t_elem             r_perm [NUM_ELEM];

    t_cell             w_cell [NUM_ELEM];
    t_cell             w_tail;
    logic [NUM_ELEM-1:0] w_used;
    logic              w_accept;
    logic              w_in_ok;
    logic              w_load;
    logic              w_shift;
    logic [RANK_W-1:0] w_weight;
    logic              w_take;
    logic              w_skip;
    logic              w_pick;

    assign w_accept = start && (r_state == ST_IDLE);
    assign w_in_ok  = i_rank < RANK_LIMIT;
    assign w_load   = w_accept && w_in_ok;
    assign w_shift  = (r_state == ST_RUN);

    // Head of the ring is cell 0. Within a pass, walk the unused elements
    // in list order: skip one per weight the remaining rank still covers,
    // and pick the first one it does not.
    assign w_weight = fact_weight(r_pass);
    assign w_take   = w_shift && !w_cell[0].used && !r_picked;
    assign w_skip   = w_take && (r_rank >= w_weight);
    assign w_pick   = w_take && (r_rank < w_weight);

    // Recirculate the head to the tail, marked used once it is picked.
    always_comb begin
        w_tail      = w_cell[0];
        w_tail.used = w_cell[0].used | w_pick;
    end

    for (genvar g = 0; g < NUM_ELEM; g++) begin : g_ring
        t_cell w_init;
        t_cell w_next;

        assign w_init = '{used: 1'b0, elem: ELEM_W'(g)};

        if (g == NUM_ELEM - 1) begin : g_last
            assign w_next = w_tail;
        end else begin : g_mid
            assign w_next = w_cell[g+1];
        end

        pur_cell u_cell (
            .i_clk   (i_clk),
            .i_load  (w_load),
            .i_init  (w_init),
            .i_shift (w_shift),
            .i_next  (w_next),
            .o_cell  (w_cell[g])
        );

        assign w_used[g] = w_cell[g].used;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_strobe <= 1'b0;
            r_picked <= 1'b0;
            r_cyc    <= '0;
            r_pass   <= '0;
        end else begin
            r_strobe <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_rank_ok <= w_in_ok;
                        r_rank    <= i_rank;
                        r_picked  <= 1'b0;
                        r_cyc     <= '0;
                        r_pass    <= '0;
                        if (w_in_ok) begin
                            r_state <= ST_RUN;
                        end else begin
                            // Out of range: show the identity right away.
                            for (int i = 0; i < NUM_ELEM; i++) begin
                                r_perm[i] <= ELEM_W'(i);
                            end
                            r_strobe <= 1'b1;
                        end
                    end
                end
                ST_RUN: begin
                    if (w_skip) begin
                        r_rank <= r_rank - w_weight;
                    end
                    // Shift picked elements in from the top; after ten
                    // picks the first one sits at position 0.
                    if (w_pick) begin
                        for (int i = 0; i < NUM_ELEM - 1; i++) begin
                            r_perm[i] <= r_perm[i+1];
                        end
                        r_perm[NUM_ELEM-1] <= w_cell[0].elem;
                    end
                    if (r_cyc == LAST_IDX) begin
                        r_cyc    <= '0;
                        r_picked <= 1'b0;
                        if (r_pass == LAST_IDX) begin
                            r_state  <= ST_IDLE;
                            r_strobe <= 1'b1;
                        end else begin
                            r_pass <= r_pass + 1'b1;
                        end
                    end else begin
                        r_cyc    <= r_cyc + 1'b1;
                        r_picked <= r_picked | w_pick;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy      = (r_state == ST_RUN);
    assign o_strobe  = r_strobe;
    assign o_rank_ok = r_rank_ok;
    assign o_perm_0  = r_perm[0];
    assign o_perm_1  = r_perm[1];
    assign o_perm_2  = r_perm[2];
    assign o_perm_3  = r_perm[3];
    assign o_perm_4  = r_perm[4];
    assign o_perm_5  = r_perm[5];
    assign o_perm_6  = r_perm[6];
    assign o_perm_7  = r_perm[7];
    assign o_perm_8  = r_perm[8];
    assign o_perm_9  = r_perm[9];

    // Every pass must pick an element before the ring comes round.
    `ASSERT_IMPL(a_pass_picks, i_clk, i_rst_n, (r_state == ST_RUN) && (r_cyc == LAST_IDX), r_picked || w_pick)
    // A result is never shown while a rank is still in the ring.
    `ASSERT_IMPL(a_strobe_idle, i_clk, i_rst_n, r_strobe, !busy)
    // An out-of-range rank is answered in the next cycle, flagged.
    `ASSERT_NEXT(a_bad_rank, i_clk, i_rst_n, w_accept && !w_in_ok, r_strobe && !r_rank_ok && !busy)
    // A valid rank starts the scan.
    `ASSERT_NEXT(a_good_rank, i_clk, i_rst_n, w_accept && w_in_ok, busy && !r_strobe)
    // A valid result has used every element.
    `ASSERT_IMPL(a_all_used, i_clk, i_rst_n, r_strobe && r_rank_ok, &w_used)

endmodule
